// ----- rtl/touch_digit_tone_generator_top_assert.svh -----
// Assertion macros shared by the touch digit tone generator RTL.
`ifndef TOUCH_DIGIT_TONE_GENERATOR_TOP_ASSERT_SVH
`define TOUCH_DIGIT_TONE_GENERATOR_TOP_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define TDTG_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("tdtg assertion failed");

// Check a condition in the cycle after its trigger.
`define TDTG_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("tdtg assertion failed");

`endif

// ----- rtl/tdtg_pkg.sv -----
// Package for the touch digit tone generator: widths, codes, payload types, helpers.
package tdtg_pkg;

  localparam int NUM_CH    = 4;
  localparam int THR_W     = 22;
  localparam int CFG_IDX_W = 3;
  localparam int PRESS_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int FREQ_W    = 14;
  localparam int DIVS_W    = FREQ_W + 1;
  localparam int HP_W      = 19;

  localparam int DEF_TICK_RATE    = 1000000;
  localparam int DEF_HZ_PER_COUNT = 50;
  localparam int DEF_PRESS_WRAP   = 20;
  localparam int DEF_COUNT_WIDTH  = 16;

  localparam logic [FREQ_W-1:0] DEC_THOUSAND = FREQ_W'(1000);
  localparam logic [FREQ_W-1:0] DEC_HUNDRED  = FREQ_W'(100);
  localparam logic [FREQ_W-1:0] DEC_TEN      = FREQ_W'(10);

  // Threshold reset values, channel 3 first
  localparam logic [NUM_CH-1:0][THR_W-1:0] OFF_RESET = {
    THR_W'(56550), THR_W'(49000), THR_W'(52750), THR_W'(60400)
  };
  localparam logic [NUM_CH-1:0][THR_W-1:0] ON_RESET = {
    THR_W'(56320), THR_W'(48750), THR_W'(52600), THR_W'(60000)
  };

  typedef enum logic [1:0] {
    ACT_EDGE   = 2'd0,
    ACT_WINDOW = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KEY_OFF     = 2'd0,
    KEY_ON      = 2'd1,
    KEY_UNKNOWN = 2'd2,
    KEY_NONE    = 2'd3
  } key_status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] channel;
  } tdtg_in_t;

  typedef struct packed {
    logic [1:0]         key_status;
    logic [DIGIT_W-1:0] digit_thousands;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_units;
    logic [FREQ_W-1:0]  tone_frequency;
    logic               wave_level;
  } tdtg_out_t;

  // Form the decimal frequency from four digits
  function automatic logic [FREQ_W-1:0] freq_of(input logic [DIGIT_W-1:0] d0,
                                                input logic [DIGIT_W-1:0] d1,
                                                input logic [DIGIT_W-1:0] d2,
                                                input logic [DIGIT_W-1:0] d3);
    freq_of = FREQ_W'(d0) * DEC_THOUSAND + FREQ_W'(d1) * DEC_HUNDRED
            + FREQ_W'(d2) * DEC_TEN + FREQ_W'(d3);
  endfunction

endpackage

// ----- rtl/touch_digit_tone_generator_top.sv -----
// Touch digit tone generator: key classification, press digits and tone divider.
// An oscillator edge, a time tick or an unused action goes from idle straight to the
// output state. A window end passes the multiply, compare and frequency states; one
// that leaves the frequency at zero then goes to output. Any other runs the restoring
// divider, forming TICK_RATE / (2 f) one quotient bit per cycle over DIV_W bits, where
// DIV_W is the bit width of TICK_RATE, then the return and output states. in_stall stays
// high from acceptance until the result is loaded into the output register, so the
// next transaction can be accepted at the edge after that load at the earliest; a
// result held by out_stall delays loading of the next one.
`include "touch_digit_tone_generator_top_assert.svh"

module touch_digit_tone_generator_top import tdtg_pkg::*; #(
  parameter int TICK_RATE    = DEF_TICK_RATE,
  parameter int HZ_PER_COUNT = DEF_HZ_PER_COUNT,
  parameter int PRESS_WRAP   = DEF_PRESS_WRAP,
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tdtg_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tdtg_out_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THR_W-1:0]     cfg_wdata
);

  localparam int HZ_W  = COUNT_WIDTH + $clog2(HZ_PER_COUNT + 1);
  localparam int CMP_W = (HZ_W > THR_W) ? HZ_W : THR_W;
  localparam int DIV_W = $clog2(TICK_RATE + 1);
  localparam int BIT_W = $clog2(DIV_W);
  localparam int QX_W  = (DIV_W > HP_W) ? DIV_W : HP_W;
  localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(TICK_RATE);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_FREQ = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_RET  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r;

  logic [NUM_CH-1:0][THR_W-1:0]       thr_off_r;
  logic [NUM_CH-1:0][THR_W-1:0]       thr_on_r;
  logic [NUM_CH-1:0][COUNT_WIDTH-1:0] edge_counter_r;
  logic [NUM_CH-1:0]                  seen_off_r;
  logic [NUM_CH-1:0]                  seen_on_r;
  logic [NUM_CH-1:0][PRESS_W-1:0]     press_count_r;
  logic [HP_W-1:0]                    half_period_r;
  logic [HP_W-1:0]                    tick_counter_r;
  logic                               wave_running_r;
  logic                               wave_out_r;
  logic                               out_valid_r;
  tdtg_out_t                          out_data_r;

  // Datapath registers, no reset needed
  logic [1:0]             ch_r;
  logic [1:0]             status_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [HZ_W-1:0]        hz_r;
  logic [DIVS_W-1:0]      div_r;
  logic [DIVS_W-1:0]      rem_r;
  logic [DIV_W-1:0]       q_r;
  logic [BIT_W-1:0]       bit_r;

  logic                   in_acc;
  logic                   out_load;
  logic [CMP_W-1:0]       hz_ext;
  logic                   is_off;
  logic                   is_on;
  logic                   off_nxt;
  logic                   on_nxt;
  logic [PRESS_W-1:0]     press_inc;
  logic [FREQ_W-1:0]      freq_now;
  logic [DIVS_W:0]        rem_shift;
  logic                   q_bit;
  logic [DIVS_W-1:0]      rem_nxt;
  logic [QX_W-1:0]        q_ext;
  logic [HP_W-1:0]        hp_nxt;
  logic [HP_W-1:0]        tick_inc;
  logic                   press_in_range;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // Classify the latched count against the channel's thresholds
  assign hz_ext = CMP_W'(hz_r);
  assign is_off = hz_ext > CMP_W'(thr_off_r[ch_r]);
  assign is_on  = !is_off && (hz_ext < CMP_W'(thr_on_r[ch_r]));
  assign off_nxt   = seen_off_r[ch_r] || is_off;
  assign on_nxt    = seen_on_r[ch_r] || is_on;
  assign press_inc = press_count_r[ch_r] + PRESS_W'(1);

  assign freq_now = freq_of(press_count_r[0][PRESS_W-1:1], press_count_r[1][PRESS_W-1:1],
                            press_count_r[2][PRESS_W-1:1], press_count_r[3][PRESS_W-1:1]);

  // Every press count stays below the wrap value
  assign press_in_range = (press_count_r[0] < PRESS_W'(PRESS_WRAP)) &&
                          (press_count_r[1] < PRESS_W'(PRESS_WRAP)) &&
                          (press_count_r[2] < PRESS_W'(PRESS_WRAP)) &&
                          (press_count_r[3] < PRESS_W'(PRESS_WRAP));

  // One restoring division step
  always_comb begin
    rem_shift = {rem_r, DIVIDEND[bit_r]};
    q_bit     = rem_shift >= {1'b0, div_r};
    if (q_bit) begin
      rem_nxt = DIVS_W'(rem_shift - {1'b0, div_r});
    end else begin
      rem_nxt = rem_shift[DIVS_W-1:0];
    end
  end

  // Clamp the quotient to the half period range
  always_comb begin
    q_ext = QX_W'(q_r);
    if (q_ext == '0) begin
      hp_nxt = HP_W'(1);
    end else if (q_ext > QX_W'({HP_W{1'b1}})) begin
      hp_nxt = {HP_W{1'b1}};
    end else begin
      hp_nxt = q_ext[HP_W-1:0];
    end
  end

  assign tick_inc = tick_counter_r + HP_W'(1);

  // Sequencer and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      thr_off_r      <= OFF_RESET;
      thr_on_r       <= ON_RESET;
      edge_counter_r <= '0;
      seen_off_r     <= '0;
      seen_on_r      <= '0;
      press_count_r  <= '0;
      half_period_r  <= '0;
      tick_counter_r <= '0;
      wave_running_r <= 1'b0;
      wave_out_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      // Take threshold writes; even index is the off threshold
      if (cfg_we) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (cfg_index == CFG_IDX_W'(2 * i)) begin
            thr_off_r[i] <= cfg_wdata;
          end
          if (cfg_index == CFG_IDX_W'(2 * i + 1)) begin
            thr_on_r[i] <= cfg_wdata;
          end
        end
      end

      // Drop the result once taken, load a new one
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.action)
              ACT_EDGE: begin
                edge_counter_r[in_data.channel] <=
                  edge_counter_r[in_data.channel] + COUNT_WIDTH'(1);
                state_r <= S_OUT;
              end
              ACT_WINDOW: begin
                edge_counter_r[in_data.channel] <= '0;
                state_r <= S_MUL;
              end
              ACT_TICK: begin
                if (wave_running_r) begin
                  if (tick_inc >= half_period_r) begin
                    wave_out_r     <= !wave_out_r;
                    tick_counter_r <= '0;
                  end else begin
                    tick_counter_r <= tick_inc;
                  end
                end
                state_r <= S_OUT;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          // Step the press count once both an off and an on are seen
          if (off_nxt && on_nxt) begin
            seen_off_r[ch_r] <= 1'b0;
            seen_on_r[ch_r]  <= 1'b0;
            if (press_inc >= PRESS_W'(PRESS_WRAP)) begin
              press_count_r[ch_r] <= '0;
            end else begin
              press_count_r[ch_r] <= press_inc;
            end
          end else begin
            seen_off_r[ch_r] <= off_nxt;
            seen_on_r[ch_r]  <= on_nxt;
          end
          state_r <= S_FREQ;
        end
        S_FREQ: begin
          if (freq_now == '0) begin
            wave_running_r <= 1'b0;
            state_r        <= S_OUT;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_r == '0) begin
            state_r <= S_RET;
          end
        end
        S_RET: begin
          // Restart the wave only when the half period changes or it was stopped
          if (hp_nxt != half_period_r || !wave_running_r) begin
            half_period_r  <= hp_nxt;
            tick_counter_r <= '0;
            wave_running_r <= 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: latch the count, scale it, run the divider, hold the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r     <= in_data.channel;
      cnt_r    <= edge_counter_r[in_data.channel];
      status_r <= KEY_NONE;
    end
    if (state_r == S_MUL) begin
      hz_r <= HZ_W'(cnt_r) * HZ_W'(HZ_PER_COUNT);
    end
    if (state_r == S_CMP) begin
      if (is_off) begin
        status_r <= KEY_OFF;
      end else if (is_on) begin
        status_r <= KEY_ON;
      end else begin
        status_r <= KEY_UNKNOWN;
      end
    end
    if (state_r == S_FREQ) begin
      div_r <= {freq_now, 1'b0};
      rem_r <= '0;
      q_r   <= '0;
      bit_r <= BIT_W'(DIV_W - 1);
    end
    if (state_r == S_DIV) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[DIV_W-2:0], q_bit};
      bit_r <= bit_r - BIT_W'(1);
    end
    if (out_load) begin
      out_data_r.key_status      <= status_r;
      out_data_r.digit_thousands <= press_count_r[0][PRESS_W-1:1];
      out_data_r.digit_hundreds  <= press_count_r[1][PRESS_W-1:1];
      out_data_r.digit_tens      <= press_count_r[2][PRESS_W-1:1];
      out_data_r.digit_units     <= press_count_r[3][PRESS_W-1:1];
      out_data_r.tone_frequency  <= freq_now;
      out_data_r.wave_level      <= wave_out_r;
    end
  end

  // Checks on the sequencer, the divider and the wave state
  `TDTG_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall)
  `TDTG_ASSERT_NOW(a_div_rem_below, state_r == S_DIV, rem_r < div_r)
  `TDTG_ASSERT_NOW(a_tick_below_half, wave_running_r, tick_counter_r < half_period_r)
  `TDTG_ASSERT_NOW(a_press_below_wrap, 1'b1, press_in_range)

endmodule
